// ===== design/mesh_edge_registry_unit_defines.svh =====
// Assertion macros for the mesh edge registry.
// Included by the modules that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef MESH_EDGE_REGISTRY_UNIT_DEFINES_SVH
`define MESH_EDGE_REGISTRY_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define MER_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
`define MER_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define MER_ASSERT(label, prop, msg)
`define MER_ASSERT_IMP(label, ante, cons, msg)
`endif
`endif

// ===== design/mer_pkg.sv =====
// Shared types and constants of the mesh edge registry.
// No dependencies.
package mer_pkg;

    localparam int PT_W      = 10;
    localparam int PT_SPAN   = 1 << PT_W;
    localparam int EI_W      = 12;
    localparam int CNT_W     = 13;
    localparam int CLS_W     = 2;
    localparam int IPC_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic KIND_CLEAR = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ORDERING   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_POINTS = 2'd1;

    localparam logic [CLS_W-1:0] CLS_INTERNAL = 2'd0;
    localparam logic [CLS_W-1:0] CLS_ONE_BND  = 2'd1;
    localparam logic [CLS_W-1:0] CLS_BND_FACE = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DEG1,
        ST_DEG2,
        ST_DEG3,
        ST_SCAN,
        ST_CHECK,
        ST_LINK2,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic deg_rd;
        logic deg_we;
        logic lst_rd;
        logic lst_we;
        logic edg_rd;
        logic edg_we;
    } mem_ctl_t;

    typedef struct packed {
        logic [EI_W-1:0]  edge_index;
        logic             is_new;
        logic [CLS_W-1:0] edge_class;
        logic             store_full;
        logic [CNT_W-1:0] total_edges;
        logic [CNT_W-1:0] boundary_edges;
        logic [CNT_W-1:0] internal_edges;
        logic [CNT_W-1:0] one_boundary_edges;
    } result_t;

endpackage

// ===== design/mer_channels.sv =====
// Handshake channels of the mesh edge registry: request, response, configuration.
// Depends on mer_pkg.
interface mer_req_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [mer_pkg::PT_W-1:0]  first_point;
    logic [mer_pkg::PT_W-1:0]  second_point;
    logic                      on_boundary_face;

    modport source (output valid, kind, first_point, second_point, on_boundary_face,
                    input ready);
    modport sink   (input valid, kind, first_point, second_point, on_boundary_face,
                    output ready);
endinterface

interface mer_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [mer_pkg::EI_W-1:0]  edge_index;
    logic                      is_new;
    logic [mer_pkg::CLS_W-1:0] edge_class;
    logic                      store_full;
    logic [mer_pkg::CNT_W-1:0] total_edges;
    logic [mer_pkg::CNT_W-1:0] boundary_edges;
    logic [mer_pkg::CNT_W-1:0] internal_edges;
    logic [mer_pkg::CNT_W-1:0] one_boundary_edges;

    modport source (output valid, edge_index, is_new, edge_class, store_full, total_edges,
                    boundary_edges, internal_edges, one_boundary_edges, input ready);
    modport sink   (input valid, edge_index, is_new, edge_class, store_full, total_edges,
                    boundary_edges, internal_edges, one_boundary_edges, output ready);
endinterface

interface mer_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mer_pkg::CFG_IDX_W-1:0] index;
    logic [mer_pkg::IPC_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/mer_store.sv =====
// Edge store memories: point degrees, per-point edge lists and edge endpoints.
// Depends on mer_pkg; one write and one registered read per memory per cycle.
module mer_store #(
    parameter int NPTS       = 1024,
    parameter int MAX_DEGREE = 16,
    parameter int MAX_EDGES  = 4096,
    parameter int PA_W       = 10,
    parameter int SL_W       = 4,
    parameter int DG_W       = 5,
    parameter int EW         = 12
) (
    input  logic              clk,
    input  mer_pkg::mem_ctl_t ctl,
    input  logic [PA_W-1:0]   deg_addr,
    input  logic [DG_W-1:0]   deg_wdata,
    output logic [DG_W-1:0]   deg_rdata,
    input  logic [PA_W-1:0]   lst_pt,
    input  logic [SL_W-1:0]   lst_slot,
    input  logic [EW-1:0]     lst_wdata,
    output logic [EW-1:0]     lst_rdata,
    input  logic [EW-1:0]     edg_addr,
    input  logic [PA_W-1:0]   edg_wlo,
    input  logic [PA_W-1:0]   edg_whi,
    output logic [PA_W-1:0]   edg_rlo,
    output logic [PA_W-1:0]   edg_rhi
);

    logic [DG_W-1:0]   deg_mem [NPTS];
    logic [EW-1:0]     lst_mem [NPTS][MAX_DEGREE];
    logic [2*PA_W-1:0] edg_mem [MAX_EDGES];
    logic [2*PA_W-1:0] edg_rd_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.deg_we)
        begin
            deg_mem[deg_addr] <= deg_wdata;
        end
        if (ctl.deg_rd)
        begin
            deg_rdata <= deg_mem[deg_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.lst_we)
        begin
            lst_mem[lst_pt][lst_slot] <= lst_wdata;
        end
        if (ctl.lst_rd)
        begin
            lst_rdata <= lst_mem[lst_pt][lst_slot];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.edg_we)
        begin
            edg_mem[edg_addr] <= {edg_wlo, edg_whi};
        end
        if (ctl.edg_rd)
        begin
            edg_rd_reg <= edg_mem[edg_addr];
        end
    end

    assign edg_rlo = edg_rd_reg[2*PA_W-1:PA_W];
    assign edg_rhi = edg_rd_reg[PA_W-1:0];

endmodule

// ===== design/mer_seq.sv =====
// Sequencer of the mesh edge registry: list scan pipeline, insert, clear sweep, counters.
// Depends on mer_pkg and mesh_edge_registry_unit_defines.svh; drives mer_store.
`include "mesh_edge_registry_unit_defines.svh"

module mer_seq #(
    parameter int MAX_POINTS = 1024,
    parameter int NPTS       = 1024,
    parameter int MAX_DEGREE = 16,
    parameter int MAX_EDGES  = 4096,
    parameter int PA_W       = 10,
    parameter int SL_W       = 4,
    parameter int DG_W       = 5,
    parameter int EW         = 12,
    parameter int CW         = 13
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       idle,
    input  logic                       req_kind,
    input  logic [mer_pkg::PT_W-1:0]   req_p1,
    input  logic [mer_pkg::PT_W-1:0]   req_p2,
    input  logic                       req_bface,
    input  logic                       ordering,
    input  logic [mer_pkg::IPC_W-1:0]  int_points,
    output logic                       res_valid,
    input  logic                       res_take,
    output mer_pkg::result_t           res,
    output mer_pkg::mem_ctl_t          mem_ctl,
    output logic [PA_W-1:0]            deg_addr,
    output logic [DG_W-1:0]            deg_wdata,
    input  logic [DG_W-1:0]            deg_rdata,
    output logic [PA_W-1:0]            lst_pt,
    output logic [SL_W-1:0]            lst_slot,
    output logic [EW-1:0]              lst_wdata,
    input  logic [EW-1:0]              lst_rdata,
    output logic [EW-1:0]              edg_addr,
    output logic [PA_W-1:0]            edg_wlo,
    output logic [PA_W-1:0]            edg_whi,
    input  logic [PA_W-1:0]            edg_rlo,
    input  logic [PA_W-1:0]            edg_rhi
);

    localparam int PT_W  = mer_pkg::PT_W;
    localparam int EI_W  = mer_pkg::EI_W;
    localparam int CNT_W = mer_pkg::CNT_W;
    localparam int CLS_W = mer_pkg::CLS_W;

    mer_pkg::state_t state_reg, state_next;

    logic [PT_W-1:0]  p1_reg, p1_next, p2_reg, p2_next;
    logic             bface_reg, bface_next;
    logic [DG_W-1:0]  deg1_reg, deg1_next, deg2_reg, deg2_next;
    logic [DG_W-1:0]  iss_reg, iss_next;
    logic             s1_v_reg, s1_v_next, s2_v_reg, s2_v_next;
    logic [EW-1:0]    s2_e_reg, s2_e_next;
    logic [PA_W-1:0]  clr_idx_reg, clr_idx_next;
    logic             clr_item_reg, clr_item_next;
    logic [EW-1:0]    res_idx_reg, res_idx_next;
    logic             res_new_reg, res_new_next;
    logic [CLS_W-1:0] res_cls_reg, res_cls_next;
    logic             res_full_reg, res_full_next;
    logic [CW-1:0]    total_reg, total_next;
    logic [CW-1:0]    bcnt_reg, bcnt_next;
    logic [CW-1:0]    icnt_reg, icnt_next;
    logic [CW-1:0]    ocnt_reg, ocnt_next;

    logic [PA_W-1:0]  p1a, p2a, lo, hi;
    logic             out_of_range, hit, scan_end, full, issue, stay;
    logic             p1_bnd, p2_bnd;
    logic [CLS_W-1:0] nb;

    assign p1a = p1_reg[PA_W-1:0];
    assign p2a = p2_reg[PA_W-1:0];
    assign lo  = (p1a < p2a) ? p1a : p2a;
    assign hi  = (p1a < p2a) ? p2a : p1a;

    assign out_of_range = (32'(req_p1) >= 32'(MAX_POINTS)) || (32'(req_p2) >= 32'(MAX_POINTS));
    assign hit          = s2_v_reg && ((edg_rlo == p2a) || (edg_rhi == p2a));
    assign scan_end     = (iss_reg == deg1_reg) && !s1_v_reg && !s2_v_reg;
    assign full         = (total_reg == CW'(MAX_EDGES)) || (deg1_reg == DG_W'(MAX_DEGREE)) ||
                          ((p1_reg != p2_reg) && (deg2_reg == DG_W'(MAX_DEGREE)));
    assign p1_bnd       = {1'b0, p1_reg} >= int_points;
    assign p2_bnd       = {1'b0, p2_reg} >= int_points;
    assign nb           = {1'b0, p1_bnd} + {1'b0, p2_bnd};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mer_pkg::ST_CLEAR:
            begin
                if (clr_idx_reg == PA_W'(NPTS - 1))
                begin
                    state_next = clr_item_reg ? mer_pkg::ST_DONE : mer_pkg::ST_IDLE;
                end
            end
            mer_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (req_kind == mer_pkg::KIND_CLEAR)
                    begin
                        state_next = mer_pkg::ST_CLEAR;
                    end
                    else if (out_of_range)
                    begin
                        state_next = mer_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = mer_pkg::ST_DEG1;
                    end
                end
            end
            mer_pkg::ST_DEG1: state_next = mer_pkg::ST_DEG2;
            mer_pkg::ST_DEG2: state_next = mer_pkg::ST_DEG3;
            mer_pkg::ST_DEG3: state_next = mer_pkg::ST_SCAN;
            mer_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    state_next = mer_pkg::ST_DONE;
                end
                else if (scan_end)
                begin
                    state_next = mer_pkg::ST_CHECK;
                end
            end
            mer_pkg::ST_CHECK:
            begin
                if (full || (p1_reg == p2_reg))
                begin
                    state_next = mer_pkg::ST_DONE;
                end
                else
                begin
                    state_next = mer_pkg::ST_LINK2;
                end
            end
            mer_pkg::ST_LINK2: state_next = mer_pkg::ST_DONE;
            mer_pkg::ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = mer_pkg::ST_IDLE;
                end
            end
            default: state_next = mer_pkg::ST_IDLE;
        endcase
    end

    assign stay  = (state_reg == mer_pkg::ST_SCAN) && (state_next == mer_pkg::ST_SCAN);
    assign issue = (state_reg == mer_pkg::ST_SCAN) && (iss_reg < deg1_reg) && !hit;

    // datapath and memory control
    always_comb
    begin
        p1_next       = p1_reg;
        p2_next       = p2_reg;
        bface_next    = bface_reg;
        deg1_next     = deg1_reg;
        deg2_next     = deg2_reg;
        iss_next      = iss_reg;
        s1_v_next     = stay && issue;
        s2_v_next     = stay && s1_v_reg;
        s2_e_next     = lst_rdata;
        clr_idx_next  = clr_idx_reg;
        clr_item_next = clr_item_reg;
        res_idx_next  = res_idx_reg;
        res_new_next  = res_new_reg;
        res_cls_next  = res_cls_reg;
        res_full_next = res_full_reg;
        total_next    = total_reg;
        bcnt_next     = bcnt_reg;
        icnt_next     = icnt_reg;
        ocnt_next     = ocnt_reg;
        mem_ctl       = '0;
        deg_addr      = p1a;
        deg_wdata     = '0;
        lst_pt        = p1a;
        lst_slot      = iss_reg[SL_W-1:0];
        lst_wdata     = total_reg[EW-1:0];
        edg_addr      = lst_rdata;
        edg_wlo       = lo;
        edg_whi       = hi;

        unique case (state_reg)
            mer_pkg::ST_CLEAR:
            begin
                mem_ctl.deg_we = 1'b1;
                deg_addr       = clr_idx_reg;
                clr_idx_next   = (clr_idx_reg == PA_W'(NPTS - 1)) ? '0 : clr_idx_reg + PA_W'(1);
            end
            mer_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    p1_next       = req_p1;
                    p2_next       = req_p2;
                    bface_next    = req_bface;
                    iss_next      = '0;
                    res_idx_next  = '0;
                    res_new_next  = 1'b0;
                    res_cls_next  = mer_pkg::CLS_INTERNAL;
                    res_full_next = 1'b0;
                    if (req_kind == mer_pkg::KIND_CLEAR)
                    begin
                        clr_idx_next  = '0;
                        clr_item_next = 1'b1;
                        total_next    = '0;
                        bcnt_next     = '0;
                        icnt_next     = '0;
                        ocnt_next     = '0;
                    end
                    else if (out_of_range)
                    begin
                        res_full_next = 1'b1;
                    end
                end
            end
            mer_pkg::ST_DEG1:
            begin
                mem_ctl.deg_rd = 1'b1;
            end
            mer_pkg::ST_DEG2:
            begin
                deg1_next      = deg_rdata;
                mem_ctl.deg_rd = 1'b1;
                deg_addr       = p2a;
            end
            mer_pkg::ST_DEG3:
            begin
                deg2_next = deg_rdata;
            end
            mer_pkg::ST_SCAN:
            begin
                if (issue)
                begin
                    mem_ctl.lst_rd = 1'b1;
                    iss_next       = iss_reg + DG_W'(1);
                end
                mem_ctl.edg_rd = s1_v_reg;
                if (hit)
                begin
                    res_idx_next = s2_e_reg;
                end
            end
            mer_pkg::ST_CHECK:
            begin
                if (full)
                begin
                    res_full_next = 1'b1;
                end
                else
                begin
                    mem_ctl.lst_we = 1'b1;
                    mem_ctl.deg_we = 1'b1;
                    mem_ctl.edg_we = 1'b1;
                    lst_slot       = deg1_reg[SL_W-1:0];
                    deg_wdata      = deg1_reg + DG_W'(1);
                    edg_addr       = total_reg[EW-1:0];
                    res_idx_next   = total_reg[EW-1:0];
                    res_new_next   = 1'b1;
                    total_next     = total_reg + CW'(1);
                    if (!ordering)
                    begin
                        res_cls_next = mer_pkg::CLS_INTERNAL;
                        icnt_next    = icnt_reg + CW'(1);
                    end
                    else if (bface_reg)
                    begin
                        res_cls_next = mer_pkg::CLS_BND_FACE;
                        bcnt_next    = bcnt_reg + CW'(1);
                    end
                    else
                    begin
                        res_cls_next = nb;
                        case (nb)
                            mer_pkg::CLS_INTERNAL: icnt_next = icnt_reg + CW'(1);
                            mer_pkg::CLS_ONE_BND:  ocnt_next = ocnt_reg + CW'(1);
                            default: ;
                        endcase
                    end
                end
            end
            mer_pkg::ST_LINK2:
            begin
                mem_ctl.lst_we = 1'b1;
                mem_ctl.deg_we = 1'b1;
                lst_pt         = p2a;
                lst_slot       = deg2_reg[SL_W-1:0];
                lst_wdata      = res_idx_reg;
                deg_addr       = p2a;
                deg_wdata      = deg2_reg + DG_W'(1);
            end
            mer_pkg::ST_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mer_pkg::ST_CLEAR;
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
            iss_reg      <= '0;
            clr_idx_reg  <= '0;
            clr_item_reg <= 1'b0;
            total_reg    <= '0;
            bcnt_reg     <= '0;
            icnt_reg     <= '0;
            ocnt_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_v_reg     <= s1_v_next;
            s2_v_reg     <= s2_v_next;
            iss_reg      <= iss_next;
            clr_idx_reg  <= clr_idx_next;
            clr_item_reg <= clr_item_next;
            total_reg    <= total_next;
            bcnt_reg     <= bcnt_next;
            icnt_reg     <= icnt_next;
            ocnt_reg     <= ocnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        bface_reg    <= bface_next;
        deg1_reg     <= deg1_next;
        deg2_reg     <= deg2_next;
        s2_e_reg     <= s2_e_next;
        res_idx_reg  <= res_idx_next;
        res_new_reg  <= res_new_next;
        res_cls_reg  <= res_cls_next;
        res_full_reg <= res_full_next;
    end

    assign idle      = (state_reg == mer_pkg::ST_IDLE);
    assign res_valid = (state_reg == mer_pkg::ST_DONE);

    assign res.edge_index         = EI_W'(res_idx_reg);
    assign res.is_new             = res_new_reg;
    assign res.edge_class         = res_cls_reg;
    assign res.store_full         = res_full_reg;
    assign res.total_edges        = CNT_W'(total_reg);
    assign res.boundary_edges     = CNT_W'(bcnt_reg);
    assign res.internal_edges     = CNT_W'(icnt_reg);
    assign res.one_boundary_edges = CNT_W'(ocnt_reg);

    `MER_ASSERT_IMP(a_stages_idle, state_reg != mer_pkg::ST_SCAN, !s1_v_reg && !s2_v_reg, "scan stage busy outside scan")
    `MER_ASSERT(a_total_cap, total_reg <= CW'(MAX_EDGES), "edge total above capacity")
    `MER_ASSERT(a_count_sum, (CW+2)'(bcnt_reg) + (CW+2)'(icnt_reg) + (CW+2)'(ocnt_reg) <= (CW+2)'(total_reg), "class counts exceed total")
    `MER_ASSERT_IMP(a_deg_cap, mem_ctl.deg_we, deg_wdata <= DG_W'(MAX_DEGREE), "degree write above list size")
    `MER_ASSERT_IMP(a_issue_cap, state_reg == mer_pkg::ST_SCAN, iss_reg <= deg1_reg, "list read past degree")

endmodule

// ===== design/mesh_edge_registry_unit.sv =====
// Mesh edge registry top level: configuration registers, sequencer, store, response register.
// Depends on mer_pkg, mer_channels, mer_store and mer_seq.
//
//  channel | dir | transaction
//  --------+-----+-----------------------------------------------------------
//  req     | in  | kind, first_point, second_point, on_boundary_face
//  rsp     | out | edge_index, is_new, edge_class, store_full, four counters
//  cfg     | in  | index, data; always ready
//
// A side scans up to deg list entries, at most MAX_DEGREE, where deg is the
// first point's list length; the list scan reads one list entry per cycle.
// A clear transaction sweeps the degree memory.
// After reset the same sweep runs with req.ready low.
// One transaction at a time; a pending response holds the sequencer in its
// final state until the response register frees.
module mesh_edge_registry_unit #(
    parameter int MAX_POINTS = 1024,
    parameter int MAX_DEGREE = 16,
    parameter int MAX_EDGES  = 4096
) (
    input  logic   clk,
    input  logic   rst_n,
    mer_req_if.sink   req,
    mer_rsp_if.source rsp,
    mer_cfg_if.sink   cfg
);

    localparam int NPTS = (MAX_POINTS < mer_pkg::PT_SPAN) ? MAX_POINTS : mer_pkg::PT_SPAN;
    localparam int PA_W = $clog2(NPTS);
    localparam int SL_W = $clog2(MAX_DEGREE);
    localparam int DG_W = $clog2(MAX_DEGREE + 1);
    localparam int EW   = $clog2(MAX_EDGES);
    localparam int CW   = $clog2(MAX_EDGES + 1);

    logic                      ordering_reg;
    logic [mer_pkg::IPC_W-1:0] int_points_reg;
    logic                      rsp_valid_reg, rsp_valid_next;
    mer_pkg::result_t          rsp_data_reg;

    logic              seq_idle, start, res_valid, res_take;
    mer_pkg::result_t  res;
    mer_pkg::mem_ctl_t mem_ctl;
    logic [PA_W-1:0]   deg_addr, lst_pt, edg_wlo, edg_whi, edg_rlo, edg_rhi;
    logic [DG_W-1:0]   deg_wdata, deg_rdata;
    logic [SL_W-1:0]   lst_slot;
    logic [EW-1:0]     lst_wdata, lst_rdata, edg_addr;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ordering_reg   <= 1'b0;
            int_points_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                mer_pkg::CFG_ORDERING:   ordering_reg   <= cfg.data[0];
                mer_pkg::CFG_INT_POINTS: int_points_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    assign req.ready = seq_idle;
    assign start     = req.valid && seq_idle;
    assign res_take  = res_valid && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_take)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            rsp_data_reg <= res;
        end
    end

    assign rsp.valid              = rsp_valid_reg;
    assign rsp.edge_index         = rsp_data_reg.edge_index;
    assign rsp.is_new             = rsp_data_reg.is_new;
    assign rsp.edge_class         = rsp_data_reg.edge_class;
    assign rsp.store_full         = rsp_data_reg.store_full;
    assign rsp.total_edges        = rsp_data_reg.total_edges;
    assign rsp.boundary_edges     = rsp_data_reg.boundary_edges;
    assign rsp.internal_edges     = rsp_data_reg.internal_edges;
    assign rsp.one_boundary_edges = rsp_data_reg.one_boundary_edges;

    mer_seq #(
        .MAX_POINTS (MAX_POINTS),
        .NPTS       (NPTS),
        .MAX_DEGREE (MAX_DEGREE),
        .MAX_EDGES  (MAX_EDGES),
        .PA_W       (PA_W),
        .SL_W       (SL_W),
        .DG_W       (DG_W),
        .EW         (EW),
        .CW         (CW)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .idle       (seq_idle),
        .req_kind   (req.kind),
        .req_p1     (req.first_point),
        .req_p2     (req.second_point),
        .req_bface  (req.on_boundary_face),
        .ordering   (ordering_reg),
        .int_points (int_points_reg),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res        (res),
        .mem_ctl    (mem_ctl),
        .deg_addr   (deg_addr),
        .deg_wdata  (deg_wdata),
        .deg_rdata  (deg_rdata),
        .lst_pt     (lst_pt),
        .lst_slot   (lst_slot),
        .lst_wdata  (lst_wdata),
        .lst_rdata  (lst_rdata),
        .edg_addr   (edg_addr),
        .edg_wlo    (edg_wlo),
        .edg_whi    (edg_whi),
        .edg_rlo    (edg_rlo),
        .edg_rhi    (edg_rhi)
    );

    mer_store #(
        .NPTS       (NPTS),
        .MAX_DEGREE (MAX_DEGREE),
        .MAX_EDGES  (MAX_EDGES),
        .PA_W       (PA_W),
        .SL_W       (SL_W),
        .DG_W       (DG_W),
        .EW         (EW)
    ) u_store (
        .clk       (clk),
        .ctl       (mem_ctl),
        .deg_addr  (deg_addr),
        .deg_wdata (deg_wdata),
        .deg_rdata (deg_rdata),
        .lst_pt    (lst_pt),
        .lst_slot  (lst_slot),
        .lst_wdata (lst_wdata),
        .lst_rdata (lst_rdata),
        .edg_addr  (edg_addr),
        .edg_wlo   (edg_wlo),
        .edg_whi   (edg_whi),
        .edg_rlo   (edg_rlo),
        .edg_rhi   (edg_rhi)
    );

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for mesh_edge_registry_unit: directed, random and list-overflow traffic.
// Transactions are predicted by an in-bench edge store model and checked in order.
// Depends on mer_pkg, mer_channels and the design sources.
module tb;

    localparam int MAX_DEG   = 16;
    localparam int EDGE_CAP  = 4096;
    localparam int HOLD_CYC  = 300;
    localparam longint TIMEOUT = 64'd48_000_000;

    localparam logic KIND_SIDE = 1'b0;
    localparam logic [mer_pkg::CLS_W-1:0] CLS_TWO_BND = 2'd2;

    typedef struct packed {
        logic                     kind;
        logic [mer_pkg::PT_W-1:0] first_point;
        logic [mer_pkg::PT_W-1:0] second_point;
        logic                     on_boundary_face;
    } face_side_t;

    logic clk = 1'b0;
    logic rst_n;

    mer_req_if req_ch();
    mer_rsp_if rsp_ch();
    mer_cfg_if cfg_ch();

    mesh_edge_registry_unit #(
        .MAX_POINTS(mer_pkg::PT_SPAN),
        .MAX_DEGREE(MAX_DEG),
        .MAX_EDGES (EDGE_CAP)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch),
        .cfg  (cfg_ch)
    );

    always #6 clk = ~clk;

    // edge store model
    logic [4:0]                point_deg   [mer_pkg::PT_SPAN];
    logic [mer_pkg::EI_W-1:0]  point_links [mer_pkg::PT_SPAN][MAX_DEG];
    logic [mer_pkg::PT_W-1:0]  edge_lo     [EDGE_CAP];
    logic [mer_pkg::PT_W-1:0]  edge_hi     [EDGE_CAP];
    logic [mer_pkg::CNT_W-1:0] edge_total;
    logic [mer_pkg::CNT_W-1:0] boundary_total;
    logic [mer_pkg::CNT_W-1:0] internal_total;
    logic [mer_pkg::CNT_W-1:0] one_bnd_total;
    logic                      ordering_on;
    logic [mer_pkg::IPC_W-1:0] interior_limit;

    face_side_t        pending_sides[$];
    mer_pkg::result_t  expected_results[$];
    face_side_t        side_now;

    int items_sent   = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int send_gap     = 0;
    int recv_gap     = 0;
    int n_new = 0, n_hit = 0, n_full = 0, n_clear = 0;
    logic steady   = 1'b0;
    logic rsp_hold = 1'b0;

    function automatic mer_pkg::result_t registry_step(input face_side_t s);
        mer_pkg::result_t         r;
        logic [4:0]               d_a;
        logic [mer_pkg::EI_W-1:0] e;
        logic [mer_pkg::PT_W-1:0] a, b;
        logic                     hit;
        logic [1:0]               nb;
        r = '0;
        a = s.first_point;
        b = s.second_point;
        if (s.kind == mer_pkg::KIND_CLEAR) begin
            foreach (point_deg[p]) point_deg[p] = '0;
            edge_total     = '0;
            boundary_total = '0;
            internal_total = '0;
            one_bnd_total  = '0;
            n_clear++;
        end else begin
            d_a = point_deg[a];
            hit = 1'b0;
            for (int i = 0; i < MAX_DEG; i++) begin
                if (!hit && i < d_a) begin
                    e = point_links[a][i];
                    if (edge_lo[e] == b || edge_hi[e] == b) begin
                        hit = 1'b1;
                        r.edge_index = e;
                    end
                end
            end
            if (hit) begin
                n_hit++;
            end else if (edge_total >= EDGE_CAP || d_a >= MAX_DEG ||
                         (a != b && point_deg[b] >= MAX_DEG)) begin
                r.store_full = 1'b1;
                n_full++;
            end else begin
                e = edge_total[mer_pkg::EI_W-1:0];
                point_links[a][d_a] = e;
                point_deg[a] = d_a + 5'd1;
                if (a != b) begin
                    point_links[b][point_deg[b]] = e;
                    point_deg[b] = point_deg[b] + 5'd1;
                end
                edge_lo[e] = (a < b) ? a : b;
                edge_hi[e] = (a < b) ? b : a;
                edge_total = edge_total + 1'b1;
                r.edge_index = e;
                r.is_new = 1'b1;
                n_new++;
                if (!ordering_on) begin
                    r.edge_class = mer_pkg::CLS_INTERNAL;
                    internal_total = internal_total + 1'b1;
                end else if (s.on_boundary_face) begin
                    r.edge_class = mer_pkg::CLS_BND_FACE;
                    boundary_total = boundary_total + 1'b1;
                end else begin
                    nb = {1'b0, {1'b0, a} >= interior_limit} +
                         {1'b0, {1'b0, b} >= interior_limit};
                    case (nb)
                        2'd0: begin
                            r.edge_class = mer_pkg::CLS_INTERNAL;
                            internal_total = internal_total + 1'b1;
                        end
                        2'd1: begin
                            r.edge_class = mer_pkg::CLS_ONE_BND;
                            one_bnd_total = one_bnd_total + 1'b1;
                        end
                        default: r.edge_class = CLS_TWO_BND;
                    endcase
                end
            end
        end
        r.total_edges        = edge_total;
        r.boundary_edges     = boundary_total;
        r.internal_edges     = internal_total;
        r.one_boundary_edges = one_bnd_total;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [mer_pkg::CNT_W-1:0] got,
                               input logic [mer_pkg::CNT_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d want %0d at transaction %0d",
                                      name, got, want, results_seen));
    endtask

    // request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready)
                expected_results.push_back(registry_step(side_now));
            if (!req_ch.valid || req_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end else if (pending_sides.size() != 0) begin
                    side_now = pending_sides.pop_front();
                    req_ch.kind             <= side_now.kind;
                    req_ch.first_point      <= side_now.first_point;
                    req_ch.second_point     <= side_now.second_point;
                    req_ch.on_boundary_face <= side_now.on_boundary_face;
                    req_ch.valid            <= 1'b1;
                    send_gap = pick_gap();
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // response monitor
    always @(posedge clk) begin
        mer_pkg::result_t want;
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("response with nothing outstanding");
                end else begin
                    want = expected_results.pop_front();
                    check_field("edge_index", rsp_ch.edge_index, want.edge_index);
                    check_field("is_new", rsp_ch.is_new, want.is_new);
                    check_field("edge_class", rsp_ch.edge_class, want.edge_class);
                    check_field("store_full", rsp_ch.store_full, want.store_full);
                    check_field("total_edges", rsp_ch.total_edges, want.total_edges);
                    check_field("boundary_edges", rsp_ch.boundary_edges, want.boundary_edges);
                    check_field("internal_edges", rsp_ch.internal_edges, want.internal_edges);
                    check_field("one_boundary_edges", rsp_ch.one_boundary_edges,
                                want.one_boundary_edges);
                end
                results_seen++;
            end
            if (rsp_hold) begin
                rsp_ch.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
                recv_gap = pick_gap();
            end
        end
    end

    task automatic push_side(input logic kind, input int a, input int b, input int bf);
        face_side_t s;
        s.kind             = kind;
        s.first_point      = a[mer_pkg::PT_W-1:0];
        s.second_point     = b[mer_pkg::PT_W-1:0];
        s.on_boundary_face = bf[0];
        pending_sides.push_back(s);
        items_sent++;
    endtask

    task automatic write_reg(input logic [mer_pkg::CFG_IDX_W-1:0] idx, input int value);
        @(posedge clk);
        cfg_ch.index <= idx;
        cfg_ch.data  <= value[mer_pkg::IPC_W-1:0];
        cfg_ch.valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        if (idx == mer_pkg::CFG_ORDERING)
            ordering_on = value[0];
        else
            interior_limit = value[mer_pkg::IPC_W-1:0];
    endtask

    task automatic set_mode(input int ord, input int limit);
        write_reg(mer_pkg::CFG_ORDERING, ord);
        write_reg(mer_pkg::CFG_INT_POINTS, limit);
    endtask

    task automatic wait_idle();
        wait (results_seen == items_sent);
        repeat (4) @(posedge clk);
    endtask

    // face patches over small point windows, some noise and occasional clears
    task automatic queue_mesh_traffic(input int n_items);
        int made, pick, base, span, faces, nv, f, v, bf;
        int ring [6];
        made = 0;
        while (made < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                push_side(mer_pkg::KIND_CLEAR, $urandom_range(0, mer_pkg::PT_SPAN - 1),
                          $urandom_range(0, mer_pkg::PT_SPAN - 1), $urandom_range(0, 1));
                made++;
            end else if (pick < 20) begin
                repeat (5)
                    push_side(KIND_SIDE, $urandom_range(0, mer_pkg::PT_SPAN - 1),
                              $urandom_range(0, mer_pkg::PT_SPAN - 1), $urandom_range(0, 1));
                made += 5;
            end else begin
                span  = $urandom_range(2, 24);
                base  = $urandom_range(0, mer_pkg::PT_SPAN - 1);
                if ($urandom_range(0, 1) == 1)
                    base = (interior_limit + mer_pkg::PT_SPAN - span / 2) % mer_pkg::PT_SPAN;
                faces = $urandom_range(2, 10);
                for (f = 0; f < faces; f++) begin
                    nv = $urandom_range(3, 6);
                    bf = ($urandom_range(0, 3) == 0) ? 1 : 0;
                    for (v = 0; v < nv; v++)
                        ring[v] = (base + $urandom_range(0, span - 1)) % mer_pkg::PT_SPAN;
                    for (v = 0; v < nv; v++)
                        push_side(KIND_SIDE, ring[v], ring[(v + 1) % nv], bf);
                    made += nv;
                end
            end
        end
    endtask

    initial begin
        #(TIMEOUT);
        $display("FAIL");
        $finish;
    end

    initial begin
        int ph, k;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.kind = KIND_SIDE;
        req_ch.first_point = '0;
        req_ch.second_point = '0;
        req_ch.on_boundary_face = 1'b0;
        rsp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = mer_pkg::CFG_ORDERING;
        cfg_ch.data = '0;
        foreach (point_deg[i]) point_deg[i] = '0;
        edge_total = '0;
        boundary_total = '0;
        internal_total = '0;
        one_bnd_total = '0;
        ordering_on = 1'b0;
        interior_limit = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        set_mode(1, 512);
        push_side(KIND_SIDE, 0, 1, 0);
        push_side(KIND_SIDE, 1, 0, 0);
        push_side(KIND_SIDE, 1023, 1023, 0);
        push_side(KIND_SIDE, 1023, 1023, 1);
        push_side(KIND_SIDE, 511, 512, 0);
        push_side(KIND_SIDE, 600, 3, 1);
        push_side(KIND_SIDE, 1023, 0, 1);
        for (k = 0; k < MAX_DEG; k++)
            push_side(KIND_SIDE, 7, 100 + k, 0);
        push_side(KIND_SIDE, 7, 116, 0);
        push_side(KIND_SIDE, 116, 7, 0);
        push_side(KIND_SIDE, 7, 115, 0);
        push_side(mer_pkg::KIND_CLEAR, 1023, 1023, 1);
        push_side(KIND_SIDE, 0, 1, 0);
        wait_idle();

        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_mode(0, 0);
                1: set_mode(1, 0);
                2: set_mode(1, mer_pkg::PT_SPAN);
                3: set_mode(1, $urandom_range(1, mer_pkg::PT_SPAN - 1));
                4: set_mode(0, mer_pkg::PT_SPAN - 1);
                default: set_mode(1, $urandom_range(0, mer_pkg::PT_SPAN));
            endcase
            steady = (ph == 2);
            queue_mesh_traffic(270);
            if (ph == 3) begin
                @(posedge clk);
                rsp_hold <= 1'b1;
                repeat (HOLD_CYC) @(posedge clk);
                rsp_hold <= 1'b0;
            end
            wait_idle();
        end
        steady = 1'b0;
        repeat (40) @(posedge clk);

        $display("covered %0d transactions: %0d new edges, %0d repeats, %0d overflows, %0d clears",
                 results_seen, n_new, n_hit, n_full, n_clear);
        $display("full point lists, equal points and six classification setups exercised");
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
